@@ rtl/cursor_overlay_alpha_blend_core_macros.svh @@
// Assertion macros shared by the cursor overlay RTL.
// The macros expect clk and rst_n in the scope where they are used.
// Both macros collapse to nothing when SYNTHESIS is defined.
`ifndef CURSOR_OVERLAY_ALPHA_BLEND_CORE_MACROS_SVH
`define CURSOR_OVERLAY_ALPHA_BLEND_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define COB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define COB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define COB_ASSERT_IMP(label, ante, cons)
`define COB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/cob_pkg.sv @@
// Package for the cursor overlay core: widths, codes, types and blend helpers.
// No dependencies; all RTL files but cob_ram and the macro header use it.
`default_nettype none

package cob_pkg;

    // Field and register widths.
    localparam int COORD_BITS      = 12;
    localparam int STORE_ADDR_BITS = 12;
    localparam int STORE_DEPTH     = 1 << STORE_ADDR_BITS;
    localparam int FRAME_DIM_BITS  = 13;
    localparam int CURSOR_DIM_BITS = 7;
    localparam int CHAN_BITS       = 8;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int CFG_DATA_BITS   = 13;

    // Decoupling queue between the front and the back.
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = 2;

    // Command codes of an input transaction.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // Blend constants.
    localparam logic [CHAN_BITS-1:0] CHAN_MAX    = 8'd255;
    localparam logic [15:0]          BLEND_ROUND = 16'd127;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_BGRA_MODE     = 3'd0,
        CFG_FRAME_WIDTH   = 3'd1,
        CFG_FRAME_HEIGHT  = 3'd2,
        CFG_CURSOR_LEFT   = 3'd3,
        CFG_CURSOR_TOP    = 3'd4,
        CFG_CURSOR_WIDTH  = 3'd5,
        CFG_CURSOR_HEIGHT = 3'd6
    } cfg_reg_e_t;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic                              bgra_mode;
        logic [FRAME_DIM_BITS-1:0]         frame_width;
        logic [FRAME_DIM_BITS-1:0]         frame_height;
        logic signed [FRAME_DIM_BITS-1:0]  cursor_left;
        logic signed [FRAME_DIM_BITS-1:0]  cursor_top;
        logic [CURSOR_DIM_BITS-1:0]        cursor_width;
        logic [CURSOR_DIM_BITS-1:0]        cursor_height;
    } cob_cfg_t;

    // One BGRA value.
    typedef struct packed {
        logic [CHAN_BITS-1:0] blue;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] alpha;
    } bgra_t;

    // Work handed from the front to the back. The texel alpha is already
    // zero when the pixel is not covered by the cursor.
    typedef struct packed {
        bgra_t texel;
        bgra_t pixel;
    } blend_job_t;

    // Queue status toward the producer and the consumer.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // s*a + d*(255-a) + 127; at most 65152, so 16 bits hold it.
    function automatic logic [15:0] blend_sum(input logic [CHAN_BITS-1:0] s,
                                              input logic [CHAN_BITS-1:0] d,
                                              input logic [CHAN_BITS-1:0] a);
        logic [CHAN_BITS-1:0] inv;
        logic [15:0]          fg;
        logic [15:0]          bg;
        inv = CHAN_MAX - a;
        fg  = {8'd0, s} * {8'd0, a};
        bg  = {8'd0, d} * {8'd0, inv};
        return fg + bg + BLEND_ROUND;
    endfunction

    // Exact floor(v / 255) for every v up to 65152.
    function automatic logic [CHAN_BITS-1:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
        return t[15:8];
    endfunction

endpackage

`default_nettype wire

@@ rtl/cob_in_if.sv @@
// Input channel of the cursor overlay core: loads and frame pixels.
// Depends on cob_pkg for the field widths.
`default_nettype none

interface cob_in_if;
    logic                               valid;
    logic                               ready;
    logic                               cmd;
    logic [cob_pkg::STORE_ADDR_BITS-1:0] texel_index;
    logic [cob_pkg::COORD_BITS-1:0]     pixel_x;
    logic [cob_pkg::COORD_BITS-1:0]     pixel_y;
    logic [cob_pkg::CHAN_BITS-1:0]      in_blue;
    logic [cob_pkg::CHAN_BITS-1:0]      in_green;
    logic [cob_pkg::CHAN_BITS-1:0]      in_red;
    logic [cob_pkg::CHAN_BITS-1:0]      in_alpha;

    modport source (
        output valid, cmd, texel_index, pixel_x, pixel_y,
               in_blue, in_green, in_red, in_alpha,
        input  ready
    );

    modport sink (
        input  valid, cmd, texel_index, pixel_x, pixel_y,
               in_blue, in_green, in_red, in_alpha,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/cob_out_if.sv @@
// Output channel of the cursor overlay core: one result per frame pixel.
// Depends on cob_pkg for the field widths.
`default_nettype none

interface cob_out_if;
    logic                          valid;
    logic                          ready;
    logic [cob_pkg::CHAN_BITS-1:0] out_blue;
    logic [cob_pkg::CHAN_BITS-1:0] out_green;
    logic [cob_pkg::CHAN_BITS-1:0] out_red;
    logic [cob_pkg::CHAN_BITS-1:0] out_alpha;

    modport source (
        output valid, out_blue, out_green, out_red, out_alpha,
        input  ready
    );

    modport sink (
        input  valid, out_blue, out_green, out_red, out_alpha,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/cob_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// A read and a write to the same address in one cycle return the old data.
`default_nettype none

module cob_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/cob_front.sv @@
// Front of the cursor overlay: accepts transactions, writes texel loads into
// the cursor store, classifies pixels and fetches their texel. Uses cob_pkg,
// cob_in_if and cob_ram.
`default_nettype none
`include "cursor_overlay_alpha_blend_core_macros.svh"

module cob_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cob_pkg::cob_cfg_t      cfg,
    cob_in_if.sink                      item,
    output      logic                   job_valid,
    input  wire logic                   job_ready,
    output      cob_pkg::blend_job_t    job
);

    localparam int CX_BITS = cob_pkg::FRAME_DIM_BITS + 2;
    localparam int CW      = cob_pkg::CURSOR_DIM_BITS;

    // Stage 1: classified pixel.
    logic                          s1_valid_reg, s1_valid_next;
    logic                          s1_hit_reg;
    logic [CW-1:0]                 s1_cx_reg;
    logic [CW-1:0]                 s1_cy_reg;
    cob_pkg::bgra_t                s1_pixel_reg;

    // Stage 2: texel read in flight, data in the RAM output register.
    logic                          s2_valid_reg, s2_valid_next;
    logic                          s2_hit_reg;
    cob_pkg::bgra_t                s2_pixel_reg;

    logic                          s1_free;
    logic                          s2_free;
    logic                          s1_adv;
    logic                          accept;
    logic                          load_we;
    logic                          pix_accept;
    logic signed [CX_BITS-1:0]     cx;
    logic signed [CX_BITS-1:0]     cy;
    logic                          hit;
    logic [2*CW-1:0]               row_base;
    logic [2*CW:0]                 addr_sum;
    cob_pkg::bgra_t                in_pixel;
    cob_pkg::bgra_t                texel;
    logic [31:0]                   ram_rdata;

    // Handshake and stage advance.
    assign s2_free    = !s2_valid_reg || job_ready;
    assign s1_adv     = s1_valid_reg && s2_free;
    assign s1_free    = !s1_valid_reg || s2_free;
    assign item.ready = s1_free;
    assign accept     = item.valid && s1_free;
    assign load_we    = accept && (item.cmd == cob_pkg::CMD_LOAD);
    assign pix_accept = accept && (item.cmd == cob_pkg::CMD_PIXEL);

    assign in_pixel = '{blue: item.in_blue, green: item.in_green,
                        red: item.in_red, alpha: item.in_alpha};

    // Position relative to the cursor origin; cursor edges may be negative.
    assign cx = $signed({3'b000, item.pixel_x})
              - $signed({{2{cfg.cursor_left[cob_pkg::FRAME_DIM_BITS-1]}}, cfg.cursor_left});
    assign cy = $signed({3'b000, item.pixel_y})
              - $signed({{2{cfg.cursor_top[cob_pkg::FRAME_DIM_BITS-1]}}, cfg.cursor_top});

    // Overlay test: mode, nonzero sizes, inside the frame and the cursor.
    always_comb
    begin
        hit = cfg.bgra_mode
           && (cfg.frame_width != '0) && (cfg.frame_height != '0)
           && (cfg.cursor_width != '0) && (cfg.cursor_height != '0)
           && ({1'b0, item.pixel_x} < cfg.frame_width)
           && ({1'b0, item.pixel_y} < cfg.frame_height)
           && !cx[CX_BITS-1] && !cy[CX_BITS-1]
           && (cx[CX_BITS-2:0] < {{(CX_BITS-1-CW){1'b0}}, cfg.cursor_width})
           && (cy[CX_BITS-2:0] < {{(CX_BITS-1-CW){1'b0}}, cfg.cursor_height});
    end

    // Stage valid bits.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (pix_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        s2_valid_next = s2_valid_reg;
        if (s1_adv)
        begin
            s2_valid_next = 1'b1;
        end
        else if (job_ready)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Stage payloads. Offsets are stored truncated; they fit whenever the pixel hits.
    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            s1_hit_reg   <= hit;
            s1_cx_reg    <= cx[CW-1:0];
            s1_cy_reg    <= cy[CW-1:0];
            s1_pixel_reg <= in_pixel;
        end
        if (s1_adv)
        begin
            s2_hit_reg   <= s1_hit_reg;
            s2_pixel_reg <= s1_pixel_reg;
        end
    end

    // Store address: row times cursor width plus column, wrapped to the store.
    assign row_base = s1_cy_reg * cfg.cursor_width;
    assign addr_sum = {1'b0, row_base} + {{(CW+1){1'b0}}, s1_cx_reg};

    cob_ram #(
        .WIDTH (32),
        .DEPTH (cob_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (load_we),
        .waddr (item.texel_index),
        .wdata (in_pixel),
        .re    (s1_adv),
        .raddr (addr_sum[cob_pkg::STORE_ADDR_BITS-1:0]),
        .rdata (ram_rdata)
    );

    // Job toward the queue; an uncovered pixel gets an all-zero, transparent
    // texel, so whatever the store held at that address never reaches the blend.
    assign texel     = cob_pkg::bgra_t'(ram_rdata);
    assign job_valid = s2_valid_reg;
    always_comb
    begin
        job.texel = s2_hit_reg ? texel : '0;
        job.pixel = s2_pixel_reg;
    end

    // A load may only land together with the read of an older pending pixel.
    `COB_ASSERT_IMP(a_load_after_read, load_we && s1_valid_reg, s1_adv)
    // A stalled stage 2 keeps its texel.
    `COB_ASSERT_NEXT(a_texel_held, s2_valid_reg && !job_ready, $stable(ram_rdata))
    // Stage 1 empties when it advances and nothing new enters.
    `COB_ASSERT_NEXT(a_s1_drain, s1_adv && !pix_accept, !s1_valid_reg && s2_valid_reg)

endmodule

`default_nettype wire

@@ rtl/cob_queue.sv @@
// Short queue that decouples the overlay front from the blend back.
// Depends on cob_pkg for depth and the job type.
`default_nettype none
`include "cursor_overlay_alpha_blend_core_macros.svh"

module cob_queue (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire cob_pkg::blend_job_t     push_data,
    input  wire logic                    pop,
    output      cob_pkg::blend_job_t     pop_data,
    output      cob_pkg::queue_status_t  status
);

    localparam int PB = cob_pkg::QUEUE_PTR_BITS;

    cob_pkg::blend_job_t entry_reg [cob_pkg::QUEUE_DEPTH];
    logic [PB-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PB-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [PB:0]         count_reg, count_next;

    assign status.full  = (count_reg == (PB+1)'(cob_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_data     = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `COB_ASSERT_IMP(a_no_overflow, push, !status.full)
    `COB_ASSERT_IMP(a_no_underflow, pop, !status.empty)
    `COB_ASSERT_NEXT(a_count_grows, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

`default_nettype wire

@@ rtl/cob_back.sv @@
// Back of the cursor overlay: blends texel and pixel per channel and holds
// the result in the output register. Uses cob_pkg and cob_out_if.
`default_nettype none

module cob_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  job_valid,
    output      logic                  job_ready,
    input  wire cob_pkg::blend_job_t   job,
    cob_out_if.source                  result
);

    // Stage 1: weighted channel sums.
    logic                          b1_valid_reg, b1_valid_next;
    logic [15:0]                   b1_sum_b_reg;
    logic [15:0]                   b1_sum_g_reg;
    logic [15:0]                   b1_sum_r_reg;
    logic                          b1_draw_reg;
    logic [cob_pkg::CHAN_BITS-1:0] b1_alpha_reg;

    // Output register.
    logic                          out_valid_reg, out_valid_next;
    cob_pkg::bgra_t                out_reg;

    logic                          out_free;
    logic                          b1_free;
    logic                          b1_adv;

    assign out_free  = !out_valid_reg || result.ready;
    assign b1_adv    = b1_valid_reg && out_free;
    assign b1_free   = !b1_valid_reg || out_free;
    assign job_ready = b1_free;

    // Valid bits of both stages.
    always_comb
    begin
        b1_valid_next = b1_valid_reg;
        if (job_valid && b1_free)
        begin
            b1_valid_next = 1'b1;
        end
        else if (b1_adv)
        begin
            b1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (b1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b1_valid_reg  <= b1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Blend: a transparent texel reproduces the pixel color exactly, an
    // opaque one the texel color, so one formula serves all three cases.
    always_ff @(posedge clk)
    begin
        if (job_valid && b1_free)
        begin
            b1_sum_b_reg <= cob_pkg::blend_sum(job.texel.blue, job.pixel.blue,
                                               job.texel.alpha);
            b1_sum_g_reg <= cob_pkg::blend_sum(job.texel.green, job.pixel.green,
                                               job.texel.alpha);
            b1_sum_r_reg <= cob_pkg::blend_sum(job.texel.red, job.pixel.red,
                                               job.texel.alpha);
            b1_draw_reg  <= (job.texel.alpha != '0);
            b1_alpha_reg <= job.pixel.alpha;
        end
        if (b1_adv)
        begin
            out_reg.blue  <= cob_pkg::div255(b1_sum_b_reg);
            out_reg.green <= cob_pkg::div255(b1_sum_g_reg);
            out_reg.red   <= cob_pkg::div255(b1_sum_r_reg);
            out_reg.alpha <= b1_draw_reg ? cob_pkg::CHAN_MAX : b1_alpha_reg;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.out_blue  = out_reg.blue;
    assign result.out_green = out_reg.green;
    assign result.out_red   = out_reg.red;
    assign result.out_alpha = out_reg.alpha;

endmodule

`default_nettype wire

@@ rtl/cursor_overlay_alpha_blend_core.sv @@
// Hardware cursor overlay for a BGRA pixel stream.
// Channel item: one transaction per cycle while item.ready is high. cmd load
// writes a BGRA texel into the 4096-entry cursor store and gives no result;
// cmd pixel carries a frame pixel and gives exactly one transaction on result.
// A covered pixel is replaced or blended with its texel (alpha set to 255)
// unless the texel alpha is 0; any other pixel passes through unchanged.
// Throughput: one transaction per cycle on item, one per cycle on result,
// while result.ready stays high. A pixel accepted on item passes through
// classify, store read, queue, blend and output register before it shows
// up on result; the cursor store has a single read port and a registered read.
// When result stalls, the four-entry queue and the pipeline registers keep
// filling; item.ready falls only once they are all occupied.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while the
// block is idle. Reset sets bgra_mode to 1 and the other registers to 0 and
// empties the pipeline; the cursor store keeps no reset state and must be
// loaded before pixels reach the entries they cover.
`default_nettype none

module cursor_overlay_alpha_blend_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    cob_in_if.sink                                  item,
    cob_out_if.source                               result,
    input  wire logic                               cfg_we,
    input  wire logic [cob_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [cob_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

    cob_pkg::cob_cfg_t      cfg_reg, cfg_next;
    cob_pkg::blend_job_t    front_job;
    cob_pkg::blend_job_t    back_job;
    cob_pkg::queue_status_t q_status;
    logic                   front_valid;
    logic                   back_ready;
    logic                   q_push;
    logic                   q_pop;

    // Configuration register writes; unknown indexes are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cob_pkg::cfg_reg_e_t'(cfg_index))
                cob_pkg::CFG_BGRA_MODE:     cfg_next.bgra_mode     = cfg_wdata[0];
                cob_pkg::CFG_FRAME_WIDTH:   cfg_next.frame_width   = cfg_wdata;
                cob_pkg::CFG_FRAME_HEIGHT:  cfg_next.frame_height  = cfg_wdata;
                cob_pkg::CFG_CURSOR_LEFT:   cfg_next.cursor_left   = $signed(cfg_wdata);
                cob_pkg::CFG_CURSOR_TOP:    cfg_next.cursor_top    = $signed(cfg_wdata);
                cob_pkg::CFG_CURSOR_WIDTH:
                    cfg_next.cursor_width  = cfg_wdata[cob_pkg::CURSOR_DIM_BITS-1:0];
                cob_pkg::CFG_CURSOR_HEIGHT:
                    cfg_next.cursor_height = cfg_wdata[cob_pkg::CURSOR_DIM_BITS-1:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{bgra_mode: 1'b1, frame_width: '0, frame_height: '0,
                         cursor_left: '0, cursor_top: '0,
                         cursor_width: '0, cursor_height: '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: accept, load the store, classify and fetch texels.
    cob_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .item      (item),
        .job_valid (front_valid),
        .job_ready (!q_status.full),
        .job       (front_job)
    );

    assign q_push = front_valid && !q_status.full;
    assign q_pop  = !q_status.empty && back_ready;

    // Queue between the two halves.
    cob_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_job),
        .pop       (q_pop),
        .pop_data  (back_job),
        .status    (q_status)
    );

    // Back: per-channel blend and output register.
    cob_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!q_status.empty),
        .job_ready (back_ready),
        .job       (back_job),
        .result    (result)
    );

endmodule

`default_nettype wire

@@ dv/tb_cursor_overlay_alpha_blend_core.sv @@
// Self-checking testbench for cursor_overlay_alpha_blend_core: cursor loads and frame pixels
// go in on item, overlaid pixels are checked on result against an in-bench prediction.
// Depends on cob_pkg, cob_in_if, cob_out_if and the core itself.
`default_nettype none

module tb_cursor_overlay_alpha_blend_core;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int ITEM_GOAL     = 1450;
    localparam int PHASE_ITEMS   = 90;
    localparam int REPORT_LIMIT  = 40;
    localparam int COORD_MAX     = (1 << cob_pkg::COORD_BITS) - 1;
    localparam int CHAN_FULL     = 255;
    localparam int BLEND_BIAS    = 127;
    localparam logic [cob_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED_INDEX = 3'd7;

    // One transaction waiting for the item channel.
    typedef struct {
        logic                                cmd;
        logic [cob_pkg::STORE_ADDR_BITS-1:0] texel_index;
        logic [cob_pkg::COORD_BITS-1:0]      pixel_x;
        logic [cob_pkg::COORD_BITS-1:0]      pixel_y;
        cob_pkg::bgra_t                      color;
        bit                                  drain_first;
    } stream_item_t;

    // One full register setting.
    typedef struct {
        bit bgra;
        int fw;
        int fh;
        int left;
        int top;
        int cw;
        int ch;
    } overlay_setting_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [cob_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [cob_pkg::CFG_DATA_BITS-1:0]  cfg_wdata = '0;

    cob_in_if  item_bus ();
    cob_out_if result_bus ();

    cursor_overlay_alpha_blend_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_bus),
        .result    (result_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Predicted register contents and cursor image.
    bit             bgra_on = 1'b1;
    int             frame_w = 0;
    int             frame_h = 0;
    int             cur_left = 0;
    int             cur_top = 0;
    int             cur_w = 0;
    int             cur_h = 0;
    cob_pkg::bgra_t cursor_image [cob_pkg::STORE_DEPTH];

    // Entries already covered by a queued load, used to keep pixels off unwritten texels.
    bit texel_loaded [cob_pkg::STORE_DEPTH];

    stream_item_t   item_backlog [$];
    cob_pkg::bgra_t expected_pixels [$];
    stream_item_t   on_bus;

    int generated_count = 0;
    int load_count = 0;
    int pixel_count = 0;
    int replaced_count = 0;
    int blended_count = 0;
    int clear_count = 0;
    int checked_count = 0;
    int setting_count = 0;
    int error_count = 0;
    int reported = 0;
    int cycle_count = 0;

    int burst_left = 0;
    int gap_left = 0;
    logic [31:0] ready_pattern = '1;
    int pattern_left = 0;

    // Returns 1 when the pixel is drawn with the cursor, and the texel address it uses.
    function automatic bit cover_addr(input logic [cob_pkg::COORD_BITS-1:0] x,
                                      input logic [cob_pkg::COORD_BITS-1:0] y,
                                      output int addr);
        int cx;
        int cy;
        bit hit;
        cx   = int'(x) - cur_left;
        cy   = int'(y) - cur_top;
        hit  = bgra_on && frame_w != 0 && frame_h != 0 && cur_w != 0 && cur_h != 0 &&
               int'(x) < frame_w && int'(y) < frame_h &&
               cx >= 0 && cx < cur_w && cy >= 0 && cy < cur_h;
        addr = hit ? ((cy * cur_w + cx) & (cob_pkg::STORE_DEPTH - 1)) : 0;
        return hit;
    endfunction

    // Rounded weighted mix of cursor and frame channel.
    function automatic logic [cob_pkg::CHAN_BITS-1:0] mix_channel(input int s, input int d,
                                                                  input int a);
        int v;
        v = s * a + d * (CHAN_FULL - a) + BLEND_BIAS;
        return (cob_pkg::CHAN_BITS)'(v / CHAN_FULL);
    endfunction

    // Prediction for one accepted transaction.
    task automatic absorb_item(input stream_item_t it);
        cob_pkg::bgra_t res;
        cob_pkg::bgra_t tex;
        int             addr;
        if (it.cmd == cob_pkg::CMD_LOAD)
        begin
            cursor_image[it.texel_index] = it.color;
            load_count++;
        end
        else
        begin
            res = it.color;
            pixel_count++;
            if (cover_addr(it.pixel_x, it.pixel_y, addr))
            begin
                tex = cursor_image[addr];
                if (tex.alpha == cob_pkg::CHAN_MAX)
                begin
                    res.blue  = tex.blue;
                    res.green = tex.green;
                    res.red   = tex.red;
                    res.alpha = cob_pkg::CHAN_MAX;
                    replaced_count++;
                end
                else if (tex.alpha != '0)
                begin
                    res.blue  = mix_channel(int'(tex.blue), int'(it.color.blue),
                                            int'(tex.alpha));
                    res.green = mix_channel(int'(tex.green), int'(it.color.green),
                                            int'(tex.alpha));
                    res.red   = mix_channel(int'(tex.red), int'(it.color.red),
                                            int'(tex.alpha));
                    res.alpha = cob_pkg::CHAN_MAX;
                    blended_count++;
                end
                else
                begin
                    clear_count++;
                end
            end
            expected_pixels.push_back(res);
        end
    endtask

    task automatic check_channel(input string name,
                                 input logic [cob_pkg::CHAN_BITS-1:0] want,
                                 input logic [cob_pkg::CHAN_BITS-1:0] got);
        if (got !== want)
        begin
            error_count++;
            if (reported < REPORT_LIMIT)
            begin
                reported++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        end
    endtask

    // Random texel with the interesting alpha values made frequent.
    function automatic cob_pkg::bgra_t random_texel();
        cob_pkg::bgra_t t;
        t = $urandom;
        case ($urandom_range(0, 4))
            0: t.alpha = '0;
            1: t.alpha = cob_pkg::CHAN_MAX;
            2: t.alpha = 8'd1;
            3: t.alpha = cob_pkg::CHAN_MAX - 8'd1;
            default: ;
        endcase
        return t;
    endfunction

    function automatic cob_pkg::bgra_t random_color();
        cob_pkg::bgra_t t;
        t = $urandom;
        case ($urandom_range(0, 7))
            0: t = '0;
            1: t = '1;
            default: ;
        endcase
        return t;
    endfunction

    // Mostly around the cursor, sometimes at the frame border, sometimes anywhere.
    function automatic int pick_coord(input int origin, input int span, input int limit);
        int v;
        case ($urandom_range(0, 9))
            0, 1: v = int'($urandom_range(0, COORD_MAX));
            2: v = limit - 2 + int'($urandom_range(0, 3));
            default: v = origin - 2 + int'($urandom_range(0, span + 3));
        endcase
        if (v < 0 || v > COORD_MAX)
            v = int'($urandom_range(0, COORD_MAX));
        return v;
    endfunction

    task automatic push_load(input int idx, input cob_pkg::bgra_t color);
        stream_item_t it;
        it.cmd         = cob_pkg::CMD_LOAD;
        it.texel_index = (cob_pkg::STORE_ADDR_BITS)'(idx);
        it.pixel_x     = (cob_pkg::COORD_BITS)'($urandom);
        it.pixel_y     = (cob_pkg::COORD_BITS)'($urandom);
        it.color       = color;
        it.drain_first = 1'b0;
        item_backlog.push_back(it);
        texel_loaded[idx] = 1'b1;
        generated_count++;
    endtask

    // A pixel that lands on a texel never loaded gets that load queued right before it.
    task automatic push_pixel(input int x, input int y, input cob_pkg::bgra_t color,
                              input bit drain);
        stream_item_t it;
        int           addr;
        if (cover_addr((cob_pkg::COORD_BITS)'(x), (cob_pkg::COORD_BITS)'(y), addr) &&
            !texel_loaded[addr])
            push_load(addr, random_texel());
        it.cmd         = cob_pkg::CMD_PIXEL;
        it.texel_index = (cob_pkg::STORE_ADDR_BITS)'($urandom);
        it.pixel_x     = (cob_pkg::COORD_BITS)'(x);
        it.pixel_y     = (cob_pkg::COORD_BITS)'(y);
        it.color       = color;
        it.drain_first = drain;
        item_backlog.push_back(it);
        generated_count++;
    endtask

    task automatic write_reg(input logic [cob_pkg::CFG_INDEX_BITS-1:0] idx, input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[cob_pkg::CFG_DATA_BITS-1:0];
        case (idx)
            cob_pkg::CFG_BGRA_MODE:     bgra_on  = value[0];
            cob_pkg::CFG_FRAME_WIDTH:   frame_w  = value & 32'h1FFF;
            cob_pkg::CFG_FRAME_HEIGHT:  frame_h  = value & 32'h1FFF;
            cob_pkg::CFG_CURSOR_LEFT:   cur_left = $signed(value[12:0]);
            cob_pkg::CFG_CURSOR_TOP:    cur_top  = $signed(value[12:0]);
            cob_pkg::CFG_CURSOR_WIDTH:  cur_w    = value & 32'h7F;
            cob_pkg::CFG_CURSOR_HEIGHT: cur_h    = value & 32'h7F;
            default: ;
        endcase
    endtask

    // Writes every register back to back, then index 7 if asked; the block is idle here.
    task automatic apply_setting(input overlay_setting_t s, input bit poke_unused);
        write_reg(cob_pkg::CFG_BGRA_MODE, s.bgra);
        write_reg(cob_pkg::CFG_FRAME_WIDTH, s.fw);
        write_reg(cob_pkg::CFG_FRAME_HEIGHT, s.fh);
        write_reg(cob_pkg::CFG_CURSOR_LEFT, s.left);
        write_reg(cob_pkg::CFG_CURSOR_TOP, s.top);
        write_reg(cob_pkg::CFG_CURSOR_WIDTH, s.cw);
        write_reg(cob_pkg::CFG_CURSOR_HEIGHT, s.ch);
        if (poke_unused)
            write_reg(CFG_UNUSED_INDEX, 32'h1FFF);
        @(posedge clk);
        cfg_we <= 1'b0;
        setting_count++;
    endtask

    // Waits until every queued transaction is accepted and every pixel has come back,
    // then lets any load still in the pipeline finish.
    task automatic wait_drained();
        while (item_backlog.size() != 0 || item_bus.valid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic overlay_setting_t random_setting();
        overlay_setting_t s;
        s.bgra = $urandom_range(0, 7) != 0;
        s.fw   = $urandom_range(0, 3) == 0 ? $urandom_range(1, 8191) : $urandom_range(16, 640);
        s.fh   = $urandom_range(0, 3) == 0 ? $urandom_range(1, 8191) : $urandom_range(16, 480);
        s.cw   = $urandom_range(0, 9) == 0 ? $urandom_range(1, 127) : $urandom_range(1, 16);
        s.ch   = $urandom_range(0, 9) == 0 ? $urandom_range(1, 127) : $urandom_range(1, 16);
        s.left = int'($urandom_range(0, 600)) - 64;
        s.top  = int'($urandom_range(0, 400)) - 64;
        return s;
    endfunction

    // One setting followed by a stream of loads and pixels with random content.
    task automatic run_phase(input overlay_setting_t s, input bit poke_unused);
        int start;
        int drain_at;
        bit drain_pending;
        int x;
        int y;
        apply_setting(s, poke_unused);
        start         = generated_count;
        drain_at      = $urandom_range(0, PHASE_ITEMS - 1);
        drain_pending = 1'b1;
        // A small cursor image is loaded whole, in row order, as software would do it.
        if (cur_w * cur_h > 0 && cur_w * cur_h <= 64)
            for (int i = 0; i < cur_w * cur_h; i++)
                push_load(i, random_texel());
        while (generated_count - start < PHASE_ITEMS)
        begin
            if ($urandom_range(0, 99) < 10)
            begin
                push_load($urandom_range(0, cob_pkg::STORE_DEPTH - 1), random_texel());
            end
            else
            begin
                x = pick_coord(cur_left, cur_w, frame_w);
                y = pick_coord(cur_top, cur_h, frame_h);
                push_pixel(x, y, random_color(),
                           drain_pending && generated_count - start >= drain_at);
                if (generated_count - start > drain_at)
                    drain_pending = 1'b0;
            end
        end
        wait_drained();
    endtask

    // Item driver: bursts of transactions separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin : item_driver
        stream_item_t nxt;
        bit           fire;
        bit           launch;
        if (!rst_n)
        begin
            item_bus.valid       <= 1'b0;
            item_bus.cmd         <= cob_pkg::CMD_LOAD;
            item_bus.texel_index <= '0;
            item_bus.pixel_x     <= '0;
            item_bus.pixel_y     <= '0;
            item_bus.in_blue     <= '0;
            item_bus.in_green    <= '0;
            item_bus.in_red      <= '0;
            item_bus.in_alpha    <= '0;
            burst_left     = $urandom_range(1, 48);
            gap_left       = 0;
        end
        else
        begin
            fire = item_bus.valid && item_bus.ready;
            if (fire)
                absorb_item(on_bus);
            if (!item_bus.valid || fire)
            begin
                launch = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (item_backlog.size() != 0 &&
                         (!item_backlog[0].drain_first || expected_pixels.size() == 0))
                    launch = 1'b1;
                if (launch)
                begin
                    nxt    = item_backlog.pop_front();
                    on_bus = nxt;
                    item_bus.valid       <= 1'b1;
                    item_bus.cmd         <= nxt.cmd;
                    item_bus.texel_index <= nxt.texel_index;
                    item_bus.pixel_x     <= nxt.pixel_x;
                    item_bus.pixel_y     <= nxt.pixel_y;
                    item_bus.in_blue     <= nxt.color.blue;
                    item_bus.in_green    <= nxt.color.green;
                    item_bus.in_red      <= nxt.color.red;
                    item_bus.in_alpha    <= nxt.color.alpha;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 48);
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3: gap_left = 0;
                            8:          gap_left = $urandom_range(5, 12);
                            9:          gap_left = 25;
                            default:    gap_left = $urandom_range(1, 4);
                        endcase
                    end
                end
                else
                begin
                    item_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each transaction and stalls on a shifting ready pattern.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        cob_pkg::bgra_t got;
        cob_pkg::bgra_t want;
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
            pattern_left     = 0;
        end
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                got.blue  = result_bus.out_blue;
                got.green = result_bus.out_green;
                got.red   = result_bus.out_red;
                got.alpha = result_bus.out_alpha;
                if (expected_pixels.size() == 0)
                begin
                    error_count++;
                    if (reported < REPORT_LIMIT)
                    begin
                        reported++;
                        $display("%0t: unexpected pixel, expected none, actual %h", $time, got);
                    end
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_channel("blue", want.blue, got.blue);
                    check_channel("green", want.green, got.green);
                    check_channel("red", want.red, got.red);
                    check_channel("alpha", want.alpha, got.alpha);
                    checked_count++;
                end
            end
            if (pattern_left == 0)
            begin
                case ($urandom_range(0, 4))
                    0:       ready_pattern = '1;
                    1:       ready_pattern = $urandom;
                    2:       ready_pattern = $urandom & $urandom;
                    3:       ready_pattern = $urandom | $urandom;
                    default: ready_pattern = 32'h0000_0001;
                endcase
                pattern_left = 32;
            end
            result_bus.ready <= ready_pattern[0];
            ready_pattern = ready_pattern >> 1;
            pattern_left--;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d pixels outstanding",
                     cycle_count, expected_pixels.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stimulus: directed cases first, then corner settings, then random settings.
    initial
    begin
        overlay_setting_t corner_cases [10];
        foreach (texel_loaded[i])
            texel_loaded[i] = 1'b0;

        corner_cases[0] = '{1'b0, 640, 480, 100, 50, 32, 32};
        corner_cases[1] = '{1'b1, 0, 480, 0, 0, 16, 16};
        corner_cases[2] = '{1'b1, 640, 0, 0, 0, 16, 16};
        corner_cases[3] = '{1'b1, 640, 480, 0, 0, 0, 16};
        corner_cases[4] = '{1'b1, 640, 480, 0, 0, 16, 0};
        corner_cases[5] = '{1'b1, 4096, 4096, 4095, 4095, 64, 64};
        corner_cases[6] = '{1'b1, 100, 100, -64, -32, 64, 64};
        corner_cases[7] = '{1'b1, 8191, 8191, 4000, 4000, 64, 64};
        corner_cases[8] = '{1'b1, 4096, 4096, 10, 20, 127, 127};
        corner_cases[9] = '{1'b1, 8191, 8191, -4096, -4096, 127, 127};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Cursor clipped at the top left corner: only pixels (0..1, 0..1) are covered.
        apply_setting('{1'b1, 16, 16, -2, -3, 4, 5}, 1'b0);
        push_load(14, '{8'd10, 8'd20, 8'd30, 8'd255});
        push_load(15, '{8'd40, 8'd50, 8'd60, 8'd0});
        push_load(18, '{8'd255, 8'd0, 8'd200, 8'd128});
        push_load(19, '{8'd255, 8'd255, 8'd255, 8'd1});
        push_pixel(0, 0, '{8'd1, 8'd2, 8'd3, 8'd4}, 1'b0);
        push_pixel(1, 0, '{8'd50, 8'd60, 8'd70, 8'd80}, 1'b0);
        push_pixel(0, 1, '{8'd0, 8'd255, 8'd100, 8'd7}, 1'b0);
        push_pixel(1, 1, '{8'd0, 8'd0, 8'd0, 8'd0}, 1'b0);
        push_load(19, '{8'd0, 8'd0, 8'd0, 8'd254});
        push_pixel(1, 1, '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b0);
        push_pixel(2, 0, random_color(), 1'b0);
        push_pixel(0, 2, random_color(), 1'b0);
        push_pixel(15, 15, random_color(), 1'b0);
        push_pixel(16, 0, random_color(), 1'b0);
        push_pixel(0, 16, random_color(), 1'b0);
        push_pixel(COORD_MAX, COORD_MAX, '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b0);
        push_pixel(0, 0, '{8'd0, 8'd0, 8'd0, 8'd0}, 1'b0);
        push_load(cob_pkg::STORE_DEPTH - 1, '1);
        push_load(0, '0);
        wait_drained();

        // Disabled overlay, zero sizes, extreme edges, wide frames and address wrap.
        foreach (corner_cases[i])
            run_phase(corner_cases[i], i == 0);

        while (generated_count < ITEM_GOAL)
            run_phase(random_setting(), 1'b0);

        wait_drained();
        $display("Sent %0d loads and %0d pixels under %0d register settings, checked %0d.",
                 load_count, pixel_count, setting_count, checked_count);
        $display("Cursor hits: %0d replaced, %0d blended, %0d transparent; %0d errors.",
                 replaced_count, blended_count, clear_count, error_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
